// ----- design/bmt_pkg.sv -----
// bmt_pkg: shared types and codes for the breakpoint match table
// holds the command and status codes, the fsm state type and the cell token
// no dependencies
`timescale 1ns / 1ps

package bmt_pkg;

	// command codes
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_HOLD
	} bmt_state_t;

	// query token handed from cell to cell
	typedef struct packed {
		logic        valid;
		logic [1:0]  cmd;
		logic [2:0]  kind;
		logic [31:0] addr;
		logic [15:0] ins_in;
		logic        hit;
		logic        free_seen;
		logic [15:0] ins_out;
	} bmt_token_t;

	// end-of-pass control broadcast to every cell
	typedef struct packed {
		logic finish;
		logic commit;
	} bmt_ctl_t;

endpackage

// ----- design/bmt_cell.sv -----
// bmt_cell: one matchpoint slot of the chain
// compares the passing token against its entry and forwards it one cell per cycle
// depends on bmt_pkg
`timescale 1ns / 1ps

module bmt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bmt_pkg::bmt_token_t tok_in,
	input  bmt_pkg::bmt_ctl_t   ctl,
	output bmt_pkg::bmt_token_t tok_out
);

	logic                valid_q;
	logic                pick_q;
	logic [2:0]          kind_q;
	logic [31:0]         addr_q;
	logic [15:0]         ins_q;
	logic                tok_valid_q;
	bmt_pkg::bmt_token_t tok_q;

	logic                match;
	logic                take;
	logic                is_add;
	logic                is_read;
	logic                is_rem;
	bmt_pkg::bmt_token_t tok_nxt;

	always_comb begin
		is_add  = (tok_in.cmd == bmt_pkg::CMD_ADD);
		is_rem  = (tok_in.cmd == bmt_pkg::CMD_REMOVE);
		is_read = (tok_in.cmd == bmt_pkg::CMD_LOOKUP) || is_rem;
		match   = tok_in.valid && valid_q && (tok_in.kind == kind_q) && (tok_in.addr == addr_q);
		// first free slot seen by an add claims it tentatively
		take    = tok_in.valid && is_add && !valid_q && !tok_in.free_seen;

		tok_nxt     = tok_in;
		tok_nxt.hit = tok_in.hit | match;
		if (match && is_read) begin
			tok_nxt.ins_out = ins_q;
		end
		if (take) begin
			tok_nxt.free_seen = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			pick_q      <= 1'b0;
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
			if (ctl.finish) begin
				pick_q <= 1'b0;
			end else if (take) begin
				pick_q <= 1'b1;
			end
			if (ctl.finish && ctl.commit && pick_q) begin
				valid_q <= 1'b1;
			end else if (match && is_rem) begin
				valid_q <= 1'b0;
			end
		end
	end

	// entry payload is only meaningful once valid
	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		if (take) begin
			kind_q <= tok_in.kind;
			addr_q <= tok_in.addr;
			ins_q  <= tok_in.ins_in;
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

// ----- design/breakpoint_match_table.sv -----
// breakpoint_match_table: fully associative debugger matchpoint table
// a row of ENTRIES bmt_cell slots walked by a query token, plus control and output register
// depends on bmt_pkg and bmt_cell
//
// usage
//   request channel: req_valid / req_stall carries command, match_type, address
//   and instruction_in; an item is taken on a clock edge with req_valid high and
//   req_stall low. response channel: rsp_valid / rsp_stall carries status, found
//   and instruction_out, one item per request, in request order
//   each request launches one token that moves through the cell row one cell per
//   clock, so the row length sets the timing: the response is registered once the
//   token leaves the last cell, and a new request is taken only once the previous
//   result has reached the output register (one item in flight)
//   an add claims the lowest free slot on its way down the row and the slot only
//   becomes valid at the end of the pass, once no matching key was found
//   reset clears every slot's valid mark and the control state at once; entry
//   payloads are left as they are since an invalid slot is never read
//   while the receiver stalls, the finished response waits in the output register
//   and the next request is still taken and walked; if that one finishes too, its
//   result waits in a hold register and no further request is taken
`timescale 1ns / 1ps

module breakpoint_match_table #(
	parameter int ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  match_type,
	input  logic [31:0] address,
	input  logic [15:0] instruction_in,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic        found,
	output logic [15:0] instruction_out
);

	bmt_pkg::bmt_state_t state_q, state_nxt;

	// token positions: index 0 is the launch register, index i+1 is cell i's output
	bmt_pkg::bmt_token_t chain_tok [ENTRIES+1];
	bmt_pkg::bmt_token_t head_q;
	logic                head_valid_q;
	bmt_pkg::bmt_token_t tail;
	bmt_pkg::bmt_ctl_t   ctl;

	// result of the token leaving the row
	logic [1:0]  res_status;
	logic        res_found;
	logic [15:0] res_ins;
	logic        res_commit;

	// result parked while the output register is still occupied
	logic [1:0]  hold_status_q;
	logic        hold_found_q;
	logic [15:0] hold_ins_q;

	logic        rsp_valid_q;
	logic [1:0]  status_q;
	logic        found_q;
	logic [15:0] ins_out_q;

	logic        req_take;
	logic        out_free;
	logic        load_res;
	logic        load_hold;
	logic        save_hold;

	assign req_take = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// launch register in front of the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
		end else begin
			head_valid_q <= req_take;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			head_q.valid     <= 1'b1;
			head_q.cmd       <= command;
			head_q.kind      <= match_type;
			head_q.addr      <= address;
			head_q.ins_in    <= instruction_in;
			head_q.hit       <= 1'b0;
			head_q.free_seen <= 1'b0;
			head_q.ins_out   <= 16'd0;
		end
	end

	always_comb begin
		chain_tok[0]       = head_q;
		chain_tok[0].valid = head_valid_q;
	end

	// the row of slots
	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			bmt_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (chain_tok[g]),
				.ctl     (ctl),
				.tok_out (chain_tok[g+1])
			);
		end
	endgenerate

	assign tail = chain_tok[ENTRIES];

	// final verdict once the token has seen every slot
	always_comb begin
		res_status = bmt_pkg::ST_MISSING;
		res_found  = 1'b0;
		res_ins    = 16'd0;
		res_commit = 1'b0;
		case (tail.cmd)
			bmt_pkg::CMD_ADD: begin
				if (tail.hit) begin
					res_status = bmt_pkg::ST_PRESENT;
					res_found  = 1'b1;
				end else if (tail.free_seen) begin
					res_status = bmt_pkg::ST_DONE;
					res_commit = 1'b1;
				end else begin
					res_status = bmt_pkg::ST_FULL;
				end
			end
			bmt_pkg::CMD_LOOKUP, bmt_pkg::CMD_REMOVE: begin
				if (tail.hit) begin
					res_status = bmt_pkg::ST_DONE;
					res_found  = 1'b1;
					res_ins    = tail.ins_out;
				end
			end
			default: begin
				// reserved command: reported as not found, nothing changes
				res_status = bmt_pkg::ST_MISSING;
			end
		endcase
	end

	// end of pass: the claimed slot becomes valid on a successful add, picks are dropped
	always_comb begin
		ctl.finish = tail.valid;
		ctl.commit = tail.valid && res_commit;
	end

	// control fsm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		req_stall = 1'b1;
		load_res  = 1'b0;
		load_hold = 1'b0;
		save_hold = 1'b0;
		case (state_q)
			bmt_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_nxt = bmt_pkg::S_RUN;
				end
			end
			bmt_pkg::S_RUN: begin
				if (tail.valid) begin
					if (out_free) begin
						load_res  = 1'b1;
						state_nxt = bmt_pkg::S_IDLE;
					end else begin
						save_hold = 1'b1;
						state_nxt = bmt_pkg::S_HOLD;
					end
				end
			end
			bmt_pkg::S_HOLD: begin
				if (out_free) begin
					load_hold = 1'b1;
					state_nxt = bmt_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = bmt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (save_hold) begin
			hold_status_q <= res_status;
			hold_found_q  <= res_found;
			hold_ins_q    <= res_ins;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_res || load_hold) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			status_q  <= res_status;
			found_q   <= res_found;
			ins_out_q <= res_ins;
		end else if (load_hold) begin
			status_q  <= hold_status_q;
			found_q   <= hold_found_q;
			ins_out_q <= hold_ins_q;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign found           = found_q;
	assign instruction_out = ins_out_q;

endmodule

// ----- tb/bmt_checker.sv -----
`timescale 1ns / 1ps
// bmt_checker: response checker for the breakpoint match table
// watches both channels, keeps its own copy of the slot store and compares every response
// depends on bmt_pkg
module bmt_checker #(
	parameter int ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  match_type,
	input  logic [31:0] address,
	input  logic [15:0] instruction_in,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [1:0]  status,
	input  logic        found,
	input  logic [15:0] instruction_out,
	output int          mismatches,
	output int          outstanding,
	output int          n_done,
	output int          n_present,
	output int          n_missing,
	output int          n_full
);

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [15:0] ins;
	} answer_t;

	answer_t     pending_answers[$];
	answer_t     got;
	answer_t     want;

	logic        slot_used [ENTRIES];
	logic [2:0]  slot_kind [ENTRIES];
	logic [31:0] slot_addr [ENTRIES];
	logic [15:0] slot_ins  [ENTRIES];

	// applies one command to the shadow store and returns its answer
	function automatic answer_t apply_command(input logic [1:0] cmd, input logic [2:0] kind,
			input logic [31:0] addr, input logic [15:0] ins);
		answer_t a;
		int      hit;
		int      spare;
		a.status = bmt_pkg::ST_MISSING;
		a.found = 1'b0;
		a.ins = 16'h0000;
		hit = -1;
		spare = -1;
		// walking down leaves the lowest matching and the lowest free slot
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_kind[i] == kind && slot_addr[i] == addr)
				hit = i;
			if (!slot_used[i])
				spare = i;
		end
		case (cmd)
			bmt_pkg::CMD_ADD: begin
				if (hit >= 0) begin
					a.status = bmt_pkg::ST_PRESENT;
					a.found = 1'b1;
				end else if (spare < 0) begin
					a.status = bmt_pkg::ST_FULL;
				end else begin
					slot_used[spare] = 1'b1;
					slot_kind[spare] = kind;
					slot_addr[spare] = addr;
					slot_ins[spare] = ins;
					a.status = bmt_pkg::ST_DONE;
				end
			end
			bmt_pkg::CMD_LOOKUP, bmt_pkg::CMD_REMOVE: begin
				if (hit >= 0) begin
					a.status = bmt_pkg::ST_DONE;
					a.found = 1'b1;
					a.ins = slot_ins[hit];
					if (cmd == bmt_pkg::CMD_REMOVE)
						slot_used[hit] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				slot_used[i] = 1'b0;
			pending_answers.delete();
			mismatches = 0;
			outstanding = 0;
			n_done = 0;
			n_present = 0;
			n_missing = 0;
			n_full = 0;
		end else begin
			// response first: it always belongs to an older request
			if (rsp_valid && !rsp_stall) begin
				got.status = status;
				got.found = found;
				got.ins = instruction_out;
				if (pending_answers.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: response with none pending: status %0d found %0d ins %h",
							$realtime, got.status, got.found, got.ins);
					mismatches++;
				end else begin
					want = pending_answers.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("%0t: mismatch status %0d/%0d found %0d/%0d ins %h/%h (exp/got)",
								$realtime, want.status, got.status, want.found, got.found,
								want.ins, got.ins);
						mismatches++;
					end
				end
				case (got.status)
					bmt_pkg::ST_DONE:    n_done++;
					bmt_pkg::ST_PRESENT: n_present++;
					bmt_pkg::ST_MISSING: n_missing++;
					bmt_pkg::ST_FULL:    n_full++;
					default: begin
					end
				endcase
			end
			if (req_valid && !req_stall)
				pending_answers.push_back(apply_command(command, match_type, address,
					instruction_in));
			outstanding = pending_answers.size();
		end
	end

endmodule

// ----- tb/tb_breakpoint_match_table.sv -----
`timescale 1ns / 1ps
// tb_breakpoint_match_table: stimulus and verdict for the breakpoint match table
// drives directed and pooled random commands with idle bursts on both channels
// depends on bmt_pkg, breakpoint_match_table and bmt_checker
module tb_breakpoint_match_table;

	localparam int ENTRIES      = 32;
	localparam int RANDOM_ITEMS = 1250;
	// no idling for this many final items
	localparam int QUIET_TAIL   = 150;
	// key pool a bit larger than the table so fill rounds reach full
	localparam int POOL_KEYS    = 40;
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED,
		MODE_NOISE
	} mode_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  command;
	logic [2:0]  match_type;
	logic [31:0] address;
	logic [15:0] instruction_in;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [1:0]  status;
	logic        found;
	logic [15:0] instruction_out;

	int mismatches;
	int outstanding;
	int n_done;
	int n_present;
	int n_missing;
	int n_full;

	// idle control shared by both channel drivers
	bit quiet;
	int quiet_from;
	int req_idle_odds;
	int rsp_idle_odds;
	int sent;
	int directed_count;

	logic [2:0]  pool_kind [POOL_KEYS];
	logic [31:0] pool_addr [POOL_KEYS];

	breakpoint_match_table #(
		.ENTRIES(ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.command(command),
		.match_type(match_type),
		.address(address),
		.instruction_in(instruction_in),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found(found),
		.instruction_out(instruction_out)
	);

	bmt_checker #(
		.ENTRIES(ENTRIES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.command(command),
		.match_type(match_type),
		.address(address),
		.instruction_in(instruction_in),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found(found),
		.instruction_out(instruction_out),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.n_done(n_done),
		.n_present(n_present),
		.n_missing(n_missing),
		.n_full(n_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// safety net, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("[breakpoint_match_table] ERROR");
		$finish;
	end

	// receiver side: random stall bursts
	initial begin : rsp_stall_gen
		int hold;
		hold = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!quiet && rsp_idle_odds != 0 && $urandom_range(1, rsp_idle_odds) == 1) begin
				rsp_stall <= 1'b1;
				hold = $urandom_range(1, 13) - 1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// presents one item, optionally after an idle burst, and waits for it to be taken
	// valid stays high across back to back items, so it is written once per step
	task automatic send_item(input logic [1:0] cmd, input logic [2:0] kind,
			input logic [31:0] addr, input logic [15:0] ins);
		int gap;
		gap = 0;
		quiet = (sent >= quiet_from);
		if (!quiet && req_idle_odds != 0 && $urandom_range(1, req_idle_odds) == 1)
			gap = $urandom_range(1, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		command <= cmd;
		match_type <= kind;
		address <= addr;
		instruction_in <= ins;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
	endtask

	// replaces one pool key: a fresh one, or a near miss of another key
	// (one address bit flipped, or one type bit flipped)
	task automatic renew_key(input int idx);
		int src;
		src = $urandom_range(0, POOL_KEYS - 1);
		case ($urandom_range(0, 3))
			0: begin
				pool_kind[idx] = pool_kind[src];
				pool_addr[idx] = pool_addr[src] ^ (32'h1 << $urandom_range(0, 31));
			end
			1: begin
				pool_kind[idx] = pool_kind[src] ^ (3'h1 << $urandom_range(0, 2));
				pool_addr[idx] = pool_addr[src];
			end
			default: begin
				pool_kind[idx] = 3'($urandom_range(0, 7));
				pool_addr[idx] = $urandom;
			end
		endcase
	endtask

	// one round of random items biased by mode; noise uses keys outside the pool
	task automatic random_round(input mode_t mode, input int len);
		int          pick;
		int          idx;
		logic [1:0]  cmd;
		logic [2:0]  kind;
		logic [31:0] addr;
		logic [15:0] ins;
		for (int n = 0; n < len; n++) begin
			pick = $urandom_range(0, 99);
			case (mode)
				MODE_FILL:
					cmd = (pick < 70) ? bmt_pkg::CMD_ADD : (pick < 85) ? bmt_pkg::CMD_LOOKUP :
						(pick < 97) ? bmt_pkg::CMD_REMOVE : CMD_RESERVED;
				MODE_DRAIN:
					cmd = (pick < 15) ? bmt_pkg::CMD_ADD : (pick < 40) ? bmt_pkg::CMD_LOOKUP :
						(pick < 97) ? bmt_pkg::CMD_REMOVE : CMD_RESERVED;
				MODE_MIXED:
					cmd = (pick < 33) ? bmt_pkg::CMD_ADD : (pick < 63) ? bmt_pkg::CMD_LOOKUP :
						(pick < 95) ? bmt_pkg::CMD_REMOVE : CMD_RESERVED;
				default:
					cmd = 2'($urandom_range(0, 3));
			endcase
			if (mode == MODE_NOISE) begin
				kind = 3'($urandom_range(0, 7));
				addr = $urandom;
			end else begin
				idx = $urandom_range(0, POOL_KEYS - 1);
				kind = pool_kind[idx];
				addr = pool_addr[idx];
			end
			// mostly random instructions, now and then the extremes
			case ($urandom_range(0, 15))
				0:       ins = 16'h0000;
				1:       ins = 16'hFFFF;
				default: ins = 16'($urandom_range(0, 65535));
			endcase
			send_item(cmd, kind, addr, ins);
		end
	endtask

	initial begin : stimulus
		int    goal;
		int    len;
		int    pick;
		mode_t mode;

		arst_n = 1'b0;
		req_valid = 1'b0;
		command = bmt_pkg::CMD_ADD;
		match_type = 3'd0;
		address = 32'h0;
		instruction_in = 16'h0;
		quiet = 1'b0;
		quiet_from = 32'h7FFF_FFFF;
		req_idle_odds = 3;
		rsp_idle_odds = 5;
		sent = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extreme keys and payloads, duplicate add,
		// near misses on type and address, reserved command, remove then reuse
		send_item(bmt_pkg::CMD_LOOKUP, 3'd0, 32'h0000_0000, 16'h0000);
		send_item(bmt_pkg::CMD_REMOVE, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(bmt_pkg::CMD_ADD,    3'd0, 32'h0000_0000, 16'h0000);
		send_item(bmt_pkg::CMD_ADD,    3'd7, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(bmt_pkg::CMD_ADD,    3'd0, 32'h0000_0000, 16'h1234);
		send_item(bmt_pkg::CMD_LOOKUP, 3'd0, 32'h0000_0000, 16'hFFFF);
		send_item(bmt_pkg::CMD_LOOKUP, 3'd7, 32'hFFFF_FFFF, 16'h0000);
		send_item(bmt_pkg::CMD_LOOKUP, 3'd7, 32'h0000_0000, 16'h0000);
		send_item(bmt_pkg::CMD_LOOKUP, 3'd0, 32'h8000_0000, 16'h0000);
		send_item(CMD_RESERVED,        3'd7, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(bmt_pkg::CMD_ADD,    3'd3, 32'h5555_5555, 16'hAAAA);
		send_item(bmt_pkg::CMD_ADD,    3'd4, 32'hAAAA_AAAA, 16'h5555);
		send_item(bmt_pkg::CMD_REMOVE, 3'd0, 32'h0000_0000, 16'h0000);
		send_item(bmt_pkg::CMD_REMOVE, 3'd0, 32'h0000_0000, 16'h0000);
		send_item(bmt_pkg::CMD_ADD,    3'd1, 32'h0000_0001, 16'h8001);
		send_item(bmt_pkg::CMD_LOOKUP, 3'd1, 32'h0000_0001, 16'h0000);
		send_item(bmt_pkg::CMD_REMOVE, 3'd7, 32'hFFFF_FFFF, 16'h0000);
		send_item(bmt_pkg::CMD_LOOKUP, 3'd7, 32'hFFFF_FFFF, 16'h0000);
		send_item(bmt_pkg::CMD_REMOVE, 3'd3, 32'h5555_5555, 16'h0000);
		send_item(bmt_pkg::CMD_REMOVE, 3'd4, 32'hAAAA_AAAA, 16'h0000);
		send_item(bmt_pkg::CMD_REMOVE, 3'd1, 32'h0000_0001, 16'h0000);
		directed_count = sent;

		// key pool: fresh keys, then a dozen renewals, each a fresh key or a near miss of another
		for (int i = 0; i < POOL_KEYS; i++) begin
			pool_kind[i] = 3'($urandom_range(0, 7));
			pool_addr[i] = $urandom;
		end
		for (int i = 0; i < 12; i++)
			renew_key($urandom_range(0, POOL_KEYS - 1));

		goal = directed_count + RANDOM_ITEMS;
		quiet_from = goal - QUIET_TAIL;

		// add the whole pool: the table fills and the tail gets full refusals
		for (int i = 0; i < POOL_KEYS; i++)
			send_item(bmt_pkg::CMD_ADD, pool_kind[i], pool_addr[i],
				16'($urandom_range(0, 65535)));

		// random rounds, each with its own command mix and idle pressure
		while (sent < goal) begin
			pick = $urandom_range(0, 9);
			if (pick < 3)
				mode = MODE_FILL;
			else if (pick < 6)
				mode = MODE_DRAIN;
			else if (pick < 9)
				mode = MODE_MIXED;
			else
				mode = MODE_NOISE;
			len = $urandom_range(20, 60);
			if (len > goal - sent)
				len = goal - sent;
			// a quarter of the rounds run without idling on that side
			req_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
			rsp_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
			if ($urandom_range(0, 2) == 0) begin
				for (int k = $urandom_range(1, 8); k > 0; k--)
					renew_key($urandom_range(0, POOL_KEYS - 1));
			end
			random_round(mode, len);
		end

		req_valid <= 1'b0;

		// drain, then let a few passes of the row go by for stray responses
		wait (outstanding == 0);
		repeat (2 * ENTRIES + 8) @(posedge clk);

		$display("covered %0d requests (%0d directed) over a %0d slot table",
			sent, directed_count, ENTRIES);
		$display("answers: %0d done, %0d duplicate adds, %0d misses, %0d full refusals",
			n_done, n_present, n_missing, n_full);
		if (mismatches == 0 && outstanding == 0) begin
			$display("[breakpoint_match_table] OK");
		end else begin
			$display("[breakpoint_match_table] ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/bmt_pkg.sv
design/bmt_cell.sv
design/breakpoint_match_table.sv
tb/bmt_checker.sv
tb/tb_breakpoint_match_table.sv
